// File: design/pibc_pkg.sv
// Shared constants and types for the paired interval breakpoint classifier.
`default_nettype none

package pibc_pkg;

  localparam int LETTERS         = 4;
  localparam int EARLY_CYCLES    = 12;
  localparam int MEAN_DIV        = 10;
  localparam int SHARED_LIMIT    = 3;
  localparam int SHARED_CNT_BITS = $clog2(LETTERS + 1);
  localparam int DIV_CHUNK       = 8;
  localparam int CYCLE_BITS      = 10;
  localparam int RATIO_BITS      = 16;
  localparam int RATIO_FRAC      = 8;

  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd256;

  typedef enum logic [0:0] {
    REG_MIN_OCC    = 1'b0,
    REG_SIZE_RATIO = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: design/pibc_div10.sv
// Pipelined floor divide by ten, one chunk of quotient bits per stage.
`default_nettype none

module pibc_div10 #(
  parameter int W = 42,
  localparam int NCH = (W + pibc_pkg::DIV_CHUNK - 1) / pibc_pkg::DIV_CHUNK
) (
  input  wire logic           clk,
  input  wire logic [NCH-1:0] en,
  input  wire logic [W-1:0]   din,
  output logic      [W-1:0]   dout
);
  import pibc_pkg::*;

  localparam int PW  = NCH * DIV_CHUNK;
  localparam int RW  = $clog2(MEAN_DIV);
  localparam int RW1 = RW + 1;
  localparam logic [RW:0] DIVC = RW1'(MEAN_DIV);

  logic [PW-1:0] work_r [NCH];
  logic [RW-1:0] rem_r  [NCH];

  for (genvar j = 0; j < NCH; j++) begin : g_st
    logic [PW-1:0]        w_in;
    logic [RW-1:0]        r_in;
    logic [PW-1:0]        w_nxt;
    logic [RW-1:0]        r_nxt;

    if (j == 0) begin : g_first
      assign w_in = PW'(din);
      assign r_in = '0;
    end else begin : g_next
      assign w_in = work_r[j-1];
      assign r_in = rem_r[j-1];
    end

    // restoring division, one bit per step; remainder stays below ten
    always_comb begin
      logic [RW:0]          r;
      logic [DIV_CHUNK-1:0] chunk;
      logic [DIV_CHUNK-1:0] q;
      chunk = w_in[PW-1-j*DIV_CHUNK -: DIV_CHUNK];
      r     = {1'b0, r_in};
      q     = '0;
      for (int b = DIV_CHUNK - 1; b >= 0; b--) begin
        r = {r[RW-1:0], chunk[b]};
        if (r >= DIVC) begin
          r    = r - DIVC;
          q[b] = 1'b1;
        end
      end
      w_nxt = w_in;
      w_nxt[PW-1-j*DIV_CHUNK -: DIV_CHUNK] = q;
      r_nxt = r[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        work_r[j] <= w_nxt;
        rem_r[j]  <= r_nxt;
      end
    end
  end

  assign dout = work_r[NCH-1][W-1:0];

endmodule

`default_nettype wire

// File: design/paired_interval_breakpoint_classifier_unit.sv
// Top level of the paired interval breakpoint classifier pipeline.
`default_nettype none

// Takes one tumour/normal interval pair per cycle while in_ready is high and returns
// one result per pair, in order. The letter-sum divide by ten produces 8 quotient bits
// per stage and sets the depth; the other stages are input capture, letter sums,
// threshold select, the Q8.8 ratio multiply, and the final compare into the output
// register. A stage only holds while it is full and its successor cannot advance, so
// empty slots are squeezed out under output back-pressure. Configuration registers are
// read live by the pipeline; write them only while no transfer is in flight.
module paired_interval_breakpoint_classifier_unit #(
  parameter int COUNT_BITS = 40
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire pibc_pkg::cfg_reg_t               cfg_index,
  input  wire logic [COUNT_BITS-1:0]            cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [COUNT_BITS-1:0]            in_a_end_count,
  input  wire logic [COUNT_BITS-1:0]            in_a_count_a,
  input  wire logic [COUNT_BITS-1:0]            in_a_count_c,
  input  wire logic [COUNT_BITS-1:0]            in_a_count_g,
  input  wire logic [COUNT_BITS-1:0]            in_a_count_t,
  input  wire logic [COUNT_BITS-1:0]            in_b_end_count,
  input  wire logic [COUNT_BITS-1:0]            in_b_count_a,
  input  wire logic [COUNT_BITS-1:0]            in_b_count_c,
  input  wire logic [COUNT_BITS-1:0]            in_b_count_g,
  input  wire logic [COUNT_BITS-1:0]            in_b_count_t,
  input  wire logic [pibc_pkg::CYCLE_BITS-1:0]  in_cycle_number,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_breakpoint,
  output logic [pibc_pkg::LETTERS-1:0]          out_propagate_a_mask,
  output logic [pibc_pkg::LETTERS-1:0]          out_propagate_b_mask
);
  import pibc_pkg::*;

  localparam int SUM_BITS  = COUNT_BITS + 2;
  localparam int NCH       = (SUM_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int NST       = NCH + 5;
  localparam int ST_SUM    = 1;
  localparam int ST_DIV    = 2;
  localparam int ST_THR    = NCH + 2;
  localparam int ST_MUL    = NCH + 3;
  localparam int ST_OUT    = NCH + 4;
  localparam int PROD_BITS = COUNT_BITS + RATIO_BITS;

  typedef logic [COUNT_BITS-1:0]              cnt_t;
  typedef logic [LETTERS-1:0][COUNT_BITS-1:0] cnt4_t;

  typedef struct packed {
    cnt4_t a;
    cnt4_t b;
    logic  end_hit;
    logic  shared_ok;
    logic  early;
  } pay_t;

  // configuration registers
  cnt_t                  min_occ_r;
  logic [RATIO_BITS-1:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_occ_r <= COUNT_BITS'(1);
      ratio_r   <= RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_OCC:    min_occ_r <= cfg_wdata;
        REG_SIZE_RATIO: ratio_r   <= cfg_wdata[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // per-stage valid and advance
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    if (k == NST - 1) begin : g_last
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[ST_OUT];

  // stage 0: capture
  cnt4_t a0_r, b0_r;
  cnt_t  ae0_r, be0_r;
  logic  early0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r     <= {in_a_count_t, in_a_count_g, in_a_count_c, in_a_count_a};
      b0_r     <= {in_b_count_t, in_b_count_g, in_b_count_c, in_b_count_a};
      ae0_r    <= in_a_end_count;
      be0_r    <= in_b_end_count;
      early0_r <= in_cycle_number >= CYCLE_BITS'(EARLY_CYCLES);
    end
  end

  // stage 1: letter sums and shared-letter counts
  logic [SUM_BITS-1:0]        sum_a, sum_b;
  logic [SHARED_CNT_BITS-1:0] nga, ngb;

  always_comb begin
    sum_a = (SUM_BITS'(a0_r[0]) + SUM_BITS'(a0_r[1])) +
            (SUM_BITS'(a0_r[2]) + SUM_BITS'(a0_r[3]));
    sum_b = (SUM_BITS'(b0_r[0]) + SUM_BITS'(b0_r[1])) +
            (SUM_BITS'(b0_r[2]) + SUM_BITS'(b0_r[3]));
    nga = '0;
    ngb = '0;
    for (int i = 0; i < LETTERS; i++) begin
      nga = nga + SHARED_CNT_BITS'(a0_r[i] > COUNT_BITS'(1));
      ngb = ngb + SHARED_CNT_BITS'(b0_r[i] > COUNT_BITS'(1));
    end
  end

  cnt4_t               a1_r, b1_r;
  cnt_t                ae1_r, be1_r;
  logic [SUM_BITS-1:0] sum_a1_r, sum_b1_r;
  logic                shared_ok1_r;
  logic                early1_r;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      a1_r         <= a0_r;
      b1_r         <= b0_r;
      ae1_r        <= ae0_r;
      be1_r        <= be0_r;
      sum_a1_r     <= sum_a;
      sum_b1_r     <= sum_b;
      shared_ok1_r <= (nga < SHARED_CNT_BITS'(SHARED_LIMIT)) &&
                      (ngb < SHARED_CNT_BITS'(SHARED_LIMIT));
      early1_r     <= early0_r;
    end
  end

  // divide stages
  logic [SUM_BITS-1:0] qa, qb;

  pibc_div10 #(.W(SUM_BITS)) u_div_a (
    .clk  (clk),
    .en   (en[ST_DIV +: NCH]),
    .din  (sum_a1_r),
    .dout (qa)
  );

  pibc_div10 #(.W(SUM_BITS)) u_div_b (
    .clk  (clk),
    .en   (en[ST_DIV +: NCH]),
    .din  (sum_b1_r),
    .dout (qb)
  );

  pay_t pay_div_r [NCH];

  for (genvar j = 0; j < NCH; j++) begin : g_pay
    pay_t d;
    if (j == 0) begin : g_first
      always_comb begin
        d.a         = a1_r;
        d.b         = b1_r;
        d.end_hit   = (sum_a1_r == SUM_BITS'(ae1_r)) || (sum_b1_r == SUM_BITS'(be1_r));
        d.shared_ok = shared_ok1_r;
        d.early     = early1_r;
      end
    end else begin : g_next
      assign d = pay_div_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV+j]) pay_div_r[j] <= d;
    end
  end

  // threshold select
  pay_t pay_last;
  cnt_t qa_c, qb_c, thr_a, thr_b;

  assign pay_last = pay_div_r[NCH-1];
  assign qa_c     = qa[COUNT_BITS-1:0];
  assign qb_c     = qb[COUNT_BITS-1:0];
  assign thr_a    = (pay_last.early && qa_c > min_occ_r) ? qa_c : min_occ_r;
  assign thr_b    = (pay_last.early && qb_c > min_occ_r) ? qb_c : min_occ_r;

  pay_t pay_thr_r;
  cnt_t thr_a_r, thr_b_r;

  always_ff @(posedge clk) begin
    if (en[ST_THR]) begin
      pay_thr_r <= pay_last;
      thr_a_r   <= thr_a;
      thr_b_r   <= thr_b;
    end
  end

  // ratio multiply and side-B / mask compares
  logic [LETTERS-1:0] gea, geb, az, bz, unsh_b;

  always_comb begin
    for (int i = 0; i < LETTERS; i++) begin
      az[i]     = pay_thr_r.a[i] == '0;
      bz[i]     = pay_thr_r.b[i] == '0;
      gea[i]    = pay_thr_r.a[i] >= thr_a_r;
      geb[i]    = pay_thr_r.b[i] >= thr_b_r;
      unsh_b[i] = (pay_thr_r.b[i] > thr_b_r) && az[i];
    end
  end

  logic [PROD_BITS-1:0] prod_r;
  cnt4_t                a_m_r;
  logic [LETTERS-1:0]   gea_r, geb_r, az_r, bz_r, unsh_b_r;
  logic                 end_hit_m_r, shared_ok_m_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      prod_r        <= PROD_BITS'(thr_a_r) * PROD_BITS'(ratio_r);
      a_m_r         <= pay_thr_r.a;
      gea_r         <= gea;
      geb_r         <= geb;
      az_r          <= az;
      bz_r          <= bz;
      unsh_b_r      <= unsh_b;
      end_hit_m_r   <= pay_thr_r.end_hit;
      shared_ok_m_r <= pay_thr_r.shared_ok;
    end
  end

  // scaled threshold, classification, masks
  cnt_t               scaled;
  logic [LETTERS-1:0] unsh_a;
  logic               bkpt;

  assign scaled = (|prod_r[PROD_BITS-1:COUNT_BITS+RATIO_FRAC]) ? '1 :
                  prod_r[COUNT_BITS+RATIO_FRAC-1:RATIO_FRAC];

  always_comb begin
    for (int i = 0; i < LETTERS; i++) begin
      unsh_a[i] = (a_m_r[i] > scaled) && bz_r[i];
    end
  end

  assign bkpt = (|(unsh_a | unsh_b_r)) && !end_hit_m_r && shared_ok_m_r;

  logic               bkpt_r;
  logic [LETTERS-1:0] mask_a_r, mask_b_r;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      bkpt_r   <= bkpt;
      mask_a_r <= bkpt ? (gea_r & bz_r) : gea_r;
      mask_b_r <= bkpt ? (geb_r & az_r) : geb_r;
    end
  end

  assign out_breakpoint       = bkpt_r;
  assign out_propagate_a_mask = mask_a_r;
  assign out_propagate_b_mask = mask_b_r;

endmodule

`default_nettype wire

// File: design/pibc_checker.sv
// Port-level assertions for the classifier, bound to the top level.
`default_nettype none

module pibc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_breakpoint,
  input wire logic [3:0] out_propagate_a_mask,
  input wire logic [3:0] out_propagate_b_mask
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_breakpoint) &&
      $stable(out_propagate_a_mask) && $stable(out_propagate_b_mask))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled while output side is free");

endmodule

bind paired_interval_breakpoint_classifier_unit pibc_checker u_pibc_checker (.*);

`default_nettype wire
